[rtl/wcs_pkg.sv]
package wcs_pkg;

   // Offset counter width and the width of the reported position
   localparam int OFFSET_BITS = 16;
   localparam int POS_BITS    = 16;
   localparam int WIDE_BITS   = (OFFSET_BITS > POS_BITS) ? OFFSET_BITS : POS_BITS;

   localparam int CHAR_BITS   = 8;
   localparam int STATUS_BITS = 3;
   localparam int RSP_BITS    = 24;   // status + position, padded to bytes

   localparam logic [CHAR_BITS-1:0] SEMI_CODE = 8'h3B;
   localparam logic [CHAR_BITS-1:0] STAR_CODE = 8'h2A;
   localparam logic [CHAR_BITS-1:0] NUL_CODE  = 8'h00;

   // Register map, index = byte address / 4
   localparam int ADDR_BITS = 4;
   localparam logic [1:0] REG_SPACE_A = 2'd0;
   localparam logic [1:0] REG_SPACE_B = 2'd1;
   localparam logic [1:0] REG_EOL_A   = 2'd2;
   localparam logic [1:0] REG_EOL_B   = 2'd3;

   typedef enum logic [2:0] {
      ST_NORMAL = 3'd0,
      ST_SEMI   = 3'd1,
      ST_LINE   = 3'd2,
      ST_BLOCK  = 3'd3,
      ST_STAR   = 3'd4,
      ST_DONE   = 3'd5
   } scan_state_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_SKIP   = 3'd0,
      STAT_FOUND  = 3'd1,
      STAT_END    = 3'd2,
      STAT_UNTERM = 3'd3,
      STAT_IDLE   = 3'd4
   } status_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] space_a;
      logic [CHAR_BITS-1:0] space_b;
      logic [CHAR_BITS-1:0] eol_a;
      logic [CHAR_BITS-1:0] eol_b;
   } cfg_type;

endpackage

[rtl/wcs_csr.sv]
module wcs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wcs_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output wcs_pkg::cfg_type              cfg
);

   wcs_pkg::cfg_type cfg_ff;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.space_a <= 8'd32;
         cfg_ff.space_b <= 8'd9;
         cfg_ff.eol_a   <= 8'd13;
         cfg_ff.eol_b   <= 8'd10;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            wcs_pkg::REG_SPACE_A: cfg_ff.space_a <= csr_pwdata[7:0];
            wcs_pkg::REG_SPACE_B: cfg_ff.space_b <= csr_pwdata[7:0];
            wcs_pkg::REG_EOL_A:   cfg_ff.eol_a   <= csr_pwdata[7:0];
            wcs_pkg::REG_EOL_B:   cfg_ff.eol_b   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = 32'd0;
      case (csr_paddr[3:2])
         wcs_pkg::REG_SPACE_A: csr_prdata = {24'd0, cfg_ff.space_a};
         wcs_pkg::REG_SPACE_B: csr_prdata = {24'd0, cfg_ff.space_b};
         wcs_pkg::REG_EOL_A:   csr_prdata = {24'd0, cfg_ff.eol_a};
         wcs_pkg::REG_EOL_B:   csr_prdata = {24'd0, cfg_ff.eol_b};
         default:              csr_prdata = 32'd0;
      endcase
   end

endmodule

[rtl/wcs_scan.sv]
module wcs_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [wcs_pkg::CHAR_BITS-1:0] character,
   input  logic                          start_scan,
   input  wcs_pkg::cfg_type              cfg,
   output wcs_pkg::status_type           status,
   output logic [wcs_pkg::POS_BITS-1:0]  position
);

   wcs_pkg::scan_state_type            state_ff, state_in, cur_state;
   logic [wcs_pkg::OFFSET_BITS-1:0]    offset_ff, offset_in, pos_eff;
   logic [wcs_pkg::WIDE_BITS-1:0]      pos_wide;
   logic                               is_space, is_eol, is_nul;

   assign is_space  = (character == cfg.space_a) || (character == cfg.space_b);
   assign is_eol    = (character == cfg.eol_a) || (character == cfg.eol_b);
   assign is_nul    = (character == wcs_pkg::NUL_CODE);
   assign cur_state = start_scan ? wcs_pkg::ST_NORMAL : state_ff;
   assign pos_eff   = start_scan ? '0 : offset_ff;

   // Offset saturates at all ones
   assign offset_in = (&pos_eff) ? pos_eff : pos_eff + 1'b1;

   // Position field clamps to its own width
   assign pos_wide = wcs_pkg::WIDE_BITS'(pos_eff);
   assign position = (pos_wide > wcs_pkg::WIDE_BITS'({wcs_pkg::POS_BITS{1'b1}})) ?
                     {wcs_pkg::POS_BITS{1'b1}} : pos_wide[wcs_pkg::POS_BITS-1:0];

   // Next state
   always_comb begin
      state_in = cur_state;
      case (cur_state)
         wcs_pkg::ST_NORMAL: begin
            if (character == wcs_pkg::SEMI_CODE) state_in = wcs_pkg::ST_SEMI;
            else if (is_nul)                     state_in = wcs_pkg::ST_DONE;
            else if (is_space || is_eol)         state_in = wcs_pkg::ST_NORMAL;
            else                                 state_in = wcs_pkg::ST_DONE;
         end
         wcs_pkg::ST_SEMI, wcs_pkg::ST_LINE: begin
            if (cur_state == wcs_pkg::ST_SEMI && character == wcs_pkg::STAR_CODE)
               state_in = wcs_pkg::ST_BLOCK;
            else if (is_nul) state_in = wcs_pkg::ST_DONE;
            else if (is_eol) state_in = wcs_pkg::ST_NORMAL;
            else             state_in = wcs_pkg::ST_LINE;
         end
         wcs_pkg::ST_BLOCK, wcs_pkg::ST_STAR: begin
            if (cur_state == wcs_pkg::ST_STAR && character == wcs_pkg::SEMI_CODE)
               state_in = wcs_pkg::ST_NORMAL;
            else if (is_nul)                         state_in = wcs_pkg::ST_DONE;
            else if (character == wcs_pkg::STAR_CODE) state_in = wcs_pkg::ST_STAR;
            else                                     state_in = wcs_pkg::ST_BLOCK;
         end
         default: state_in = wcs_pkg::ST_DONE;
      endcase
   end

   // Status of the current item
   always_comb begin
      status = wcs_pkg::STAT_SKIP;
      case (cur_state)
         wcs_pkg::ST_NORMAL: begin
            if (character == wcs_pkg::SEMI_CODE) status = wcs_pkg::STAT_SKIP;
            else if (is_nul)                     status = wcs_pkg::STAT_END;
            else if (is_space || is_eol)         status = wcs_pkg::STAT_SKIP;
            else                                 status = wcs_pkg::STAT_FOUND;
         end
         wcs_pkg::ST_SEMI: begin
            if (character == wcs_pkg::STAR_CODE) status = wcs_pkg::STAT_SKIP;
            else if (is_nul)                     status = wcs_pkg::STAT_END;
            else                                 status = wcs_pkg::STAT_SKIP;
         end
         wcs_pkg::ST_LINE:
            status = is_nul ? wcs_pkg::STAT_END : wcs_pkg::STAT_SKIP;
         wcs_pkg::ST_BLOCK:
            status = is_nul ? wcs_pkg::STAT_UNTERM : wcs_pkg::STAT_SKIP;
         wcs_pkg::ST_STAR: begin
            if (character == wcs_pkg::SEMI_CODE) status = wcs_pkg::STAT_SKIP;
            else if (is_nul)                     status = wcs_pkg::STAT_UNTERM;
            else                                 status = wcs_pkg::STAT_SKIP;
         end
         default: status = wcs_pkg::STAT_IDLE;
      endcase
   end

   // Scan state and offset advance once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= wcs_pkg::ST_DONE;
         offset_ff <= '0;
      end else if (advance) begin
         state_ff  <= state_in;
         offset_ff <= offset_in;
      end
   end

endmodule

[rtl/whitespace_comment_skipper.sv]
// Pipeline: input register, then result register. A result is valid once its item moves
// on from the input register, which waits while a result is stalled on rsp_tready; an
// empty input register still takes an item then. Throughput: one item per cycle unless
// rsp_tready stalls; scan state and offset update as an item enters the result register.
// Reset (synchronous, active high): scan done so items read idle until a start,
// offset zero, pipeline empty, registers at space/tab/CR/LF.
module whitespace_comment_skipper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] character
   input  logic                          req_tuser,   // [0] start_scan
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [wcs_pkg::RSP_BITS-1:0]  rsp_tdata,   // [2:0] status, [18:3] position
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wcs_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   wcs_pkg::cfg_type                    cfg;
   logic                                in_valid_ff;
   logic [wcs_pkg::CHAR_BITS-1:0]       in_char_ff;
   logic                                in_start_ff;
   logic                                out_valid_ff;
   wcs_pkg::status_type                 out_status_ff, status;
   logic [wcs_pkg::POS_BITS-1:0]        out_pos_ff, position;
   logic                                out_load, in_load;

   wcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wcs_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (out_load),
      .character  (in_char_ff),
      .start_scan (in_start_ff),
      .cfg        (cfg),
      .status     (status),
      .position   (position)
   );

   // Pipeline handshake
   assign out_load   = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | out_load;
   assign in_load    = req_tvalid & req_tready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_char_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (~out_valid_ff | rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= status;
         out_pos_ff    <= position;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_pos_ff, out_status_ff};

endmodule

[sim/scan_status_checker.sv]
`timescale 1ns / 1ps

// Watches the character and status streams plus the register port, predicts the
// status of every accepted character and compares it with what comes out.
module scan_status_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] character
   input  logic                          req_tuser,   // [0] start_scan
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [wcs_pkg::RSP_BITS-1:0]  rsp_tdata,   // [2:0] status, [18:3] position
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wcs_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic [31:0]                   csr_prdata,
   input  logic                          csr_pready,
   output int                            mismatches,
   output int                            outstanding
);
   import wcs_pkg::*;

   typedef struct {
      status_type           status;
      logic [POS_BITS-1:0]  position;
   } status_entry;

   status_entry            expected_status[$];
   scan_state_type         lex_mode;
   logic [OFFSET_BITS-1:0] char_pos;
   logic [CHAR_BITS-1:0]   lex_regs [0:3];

   status_entry            got;
   status_entry            want;
   logic [1:0]             reg_idx;

   // Status of one character; advances the scan mode and the offset
   function automatic status_entry scan_char(input logic [7:0] ch, input logic restart);
      status_entry       res;
      logic              blank;
      logic              newline;
      longint unsigned   wide_pos;
      blank   = (ch == lex_regs[REG_SPACE_A]) || (ch == lex_regs[REG_SPACE_B]);
      newline = (ch == lex_regs[REG_EOL_A]) || (ch == lex_regs[REG_EOL_B]);
      if (restart) begin
         lex_mode = ST_NORMAL;
         char_pos = '0;
      end
      wide_pos = char_pos;
      res.position = ((wide_pos >> POS_BITS) != 0) ? '1 : wide_pos[POS_BITS-1:0];

      case (lex_mode)
         ST_NORMAL: begin
            // ';' wins over a register that holds the same code
            if (ch == SEMI_CODE) begin
               lex_mode = ST_SEMI;
               res.status = STAT_SKIP;
            end else if (ch == NUL_CODE) begin
               lex_mode = ST_DONE;
               res.status = STAT_END;
            end else if (blank || newline) begin
               res.status = STAT_SKIP;
            end else begin
               lex_mode = ST_DONE;
               res.status = STAT_FOUND;
            end
         end
         ST_SEMI, ST_LINE: begin
            // a lone ';' opens a line comment at this character
            if (lex_mode == ST_SEMI && ch == STAR_CODE) begin
               lex_mode = ST_BLOCK;
               res.status = STAT_SKIP;
            end else if (ch == NUL_CODE) begin
               lex_mode = ST_DONE;
               res.status = STAT_END;
            end else begin
               lex_mode = newline ? ST_NORMAL : ST_LINE;
               res.status = STAT_SKIP;
            end
         end
         ST_BLOCK, ST_STAR: begin
            if (lex_mode == ST_STAR && ch == SEMI_CODE) begin
               lex_mode = ST_NORMAL;
               res.status = STAT_SKIP;
            end else if (ch == NUL_CODE) begin
               lex_mode = ST_DONE;
               res.status = STAT_UNTERM;
            end else begin
               lex_mode = (ch == STAR_CODE) ? ST_STAR : ST_BLOCK;
               res.status = STAT_SKIP;
            end
         end
         default: begin
            lex_mode = ST_DONE;
            res.status = STAT_IDLE;
         end
      endcase

      // offset saturates at its maximum
      if (char_pos != '1) char_pos = char_pos + 1'b1;
      return res;
   endfunction

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lex_mode = ST_DONE;
         char_pos = '0;
         lex_regs[REG_SPACE_A] = 8'd32;
         lex_regs[REG_SPACE_B] = 8'd9;
         lex_regs[REG_EOL_A]   = 8'd13;
         lex_regs[REG_EOL_B]   = 8'd10;
         expected_status.delete();
         mismatches = 0;
         outstanding = 0;
      end else begin
         // register port: track writes, check reads
         if (csr_psel && csr_penable && csr_pready) begin
            reg_idx = csr_paddr[ADDR_BITS-1:2];
            if (csr_pwrite) begin
               lex_regs[reg_idx] = csr_pwdata[7:0];
            end else if (csr_prdata !== {24'd0, lex_regs[reg_idx]}) begin
               flag($sformatf("register %0d read: expected %0h, got %0h",
                              reg_idx, {24'd0, lex_regs[reg_idx]}, csr_prdata));
            end
         end

         // status items against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.status   = status_type'(rsp_tdata[2:0]);
            got.position = rsp_tdata[18:3];
            if (expected_status.size() == 0) begin
               flag($sformatf("unexpected item: status %0d position %0d",
                              got.status, got.position));
            end else begin
               want = expected_status.pop_front();
               if (got.status !== want.status || got.position !== want.position) begin
                  flag($sformatf({"expected status %0d position %0d, ",
                                  "got status %0d position %0d"},
                                 want.status, want.position, got.status, got.position));
               end
            end
         end

         // predict each accepted character
         if (req_tvalid && req_tready) expected_status.push_back(scan_char(req_tdata, req_tuser));
         outstanding = expected_status.size();
      end
   end

endmodule

[sim/whitespace_comment_skipper_test.sv]
`timescale 1ns / 1ps

module whitespace_comment_skipper_test;
   import wcs_pkg::*;

   localparam int QUIET_LIMIT    = 2000;
   localparam int LONG_HOLD      = 300;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_tvalid  = 1'b0;
   logic                 req_tready;
   logic [CHAR_BITS-1:0] req_tdata   = '0;
   logic                 req_tuser   = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready  = 1'b0;
   logic [RSP_BITS-1:0]  rsp_tdata;
   logic                 csr_psel    = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite  = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr   = '0;
   logic [31:0]          csr_pwdata  = '0;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   int mismatches;
   int outstanding;
   int req_max_gap   = 0;
   int rsp_max_stall = 0;
   int rsp_hold      = 0;
   int items_sent    = 0;
   int scans_sent    = 0;
   int settings_used = 1;
   int quiet         = 0;

   // register values as the stimulus sees them, for building scans
   logic [7:0] reg_shadow [0:3] = '{8'd32, 8'd9, 8'd13, 8'd10};

   whitespace_comment_skipper dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   scan_status_checker scan_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // status sink: random stalls, plus one long hold-off on request
   initial begin : status_sink
      int stall;
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else begin
            stall = $urandom_range(0, rsp_max_stall);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic restart);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= restart;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // write one register, then read it back
   task automatic write_lex_reg(input logic [1:0] idx, input logic [7:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      reg_shadow[idx] = value;
   endtask

   // one scan: mostly blanks and comments ending in a terminator, sometimes noise
   task automatic send_scan;
      logic [7:0] chars[$];
      req_max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rsp_max_stall = ($urandom_range(0, 3) == 0) ? 0 : 8;
      scans_sent++;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12))
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
         repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 3))
               0: chars.push_back(reg_shadow[$urandom_range(0, 1) ? REG_SPACE_A : REG_SPACE_B]);
               1: chars.push_back(reg_shadow[$urandom_range(0, 1) ? REG_EOL_A : REG_EOL_B]);
               2: begin
                  chars.push_back(SEMI_CODE);
                  repeat ($urandom_range(0, 4)) chars.push_back(8'($urandom_range(1, 255)));
                  chars.push_back(reg_shadow[$urandom_range(0, 1) ? REG_EOL_A : REG_EOL_B]);
               end
               default: begin
                  chars.push_back(SEMI_CODE);
                  chars.push_back(STAR_CODE);
                  repeat ($urandom_range(0, 5)) begin
                     chars.push_back($urandom_range(0, 2) == 0 ? STAR_CODE
                                                               : 8'($urandom_range(1, 255)));
                  end
                  chars.push_back(STAR_CODE);
                  chars.push_back(SEMI_CODE);
               end
            endcase
         end
         // how the scan stops
         case ($urandom_range(0, 3))
            0: chars.push_back(8'($urandom_range(1, 255)));
            1: chars.push_back(NUL_CODE);
            2: begin
               chars.push_back(SEMI_CODE);
               chars.push_back(STAR_CODE);
               repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(1, 255)));
               chars.push_back(NUL_CODE);
            end
            default: begin
               chars.push_back(SEMI_CODE);
               repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(1, 255)));
               chars.push_back(NUL_CODE);
            end
         endcase
         repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(0, 255)));
         foreach (chars[i]) send_char(chars[i], i == 0);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // before any start: idle
      send_char(8'h41, 1'b0);
      send_char(NUL_CODE, 1'b0);
      // blanks and line ends, a line comment, then a block comment with a stray star
      send_char(8'h20, 1'b1);
      send_char(8'h09, 1'b0);
      send_char(8'h0A, 1'b0);
      send_char(SEMI_CODE, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h0A, 1'b0);
      send_char(SEMI_CODE, 1'b0);
      send_char(STAR_CODE, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(STAR_CODE, 1'b0);
      send_char(8'h01, 1'b0);
      send_char(STAR_CODE, 1'b0);
      send_char(SEMI_CODE, 1'b0);
      send_char(8'h7E, 1'b0);
      // zero right after ';'
      send_char(SEMI_CODE, 1'b1);
      send_char(NUL_CODE, 1'b0);
      // zero inside a line comment
      send_char(SEMI_CODE, 1'b1);
      send_char(8'h55, 1'b0);
      send_char(NUL_CODE, 1'b0);
      // zero inside a block comment just after a star
      send_char(SEMI_CODE, 1'b1);
      send_char(STAR_CODE, 1'b0);
      send_char(STAR_CODE, 1'b0);
      send_char(NUL_CODE, 1'b0);
      // zero and a significant character as first characters
      send_char(NUL_CODE, 1'b1);
      send_char(8'hFF, 1'b1);

      // reset values, with one long hold-off on the status side
      while (items_sent < 100) begin
         if (scans_sent == 8) rsp_hold = LONG_HOLD;
         send_scan();
      end

      // extremes: zero and all-ones as blanks, ';' and '*' as line ends
      write_lex_reg(REG_SPACE_A, 8'h00);
      write_lex_reg(REG_SPACE_B, 8'hFF);
      write_lex_reg(REG_EOL_A, SEMI_CODE);
      write_lex_reg(REG_EOL_B, STAR_CODE);
      settings_used++;
      while (items_sent < 190) send_scan();

      write_lex_reg(REG_SPACE_A, 8'($urandom_range(0, 255)));
      write_lex_reg(REG_SPACE_B, 8'($urandom_range(0, 255)));
      write_lex_reg(REG_EOL_A, 8'($urandom_range(0, 255)));
      write_lex_reg(REG_EOL_B, 8'($urandom_range(0, 255)));
      settings_used++;
      while (items_sent < 280) send_scan();

      write_lex_reg(REG_SPACE_A, 8'd32);
      write_lex_reg(REG_SPACE_B, 8'd9);
      write_lex_reg(REG_EOL_A, 8'd13);
      write_lex_reg(REG_EOL_B, 8'd10);
      settings_used++;
      while (items_sent < 370) send_scan();

      drain();
      repeat (10) @(posedge clock);

      $display("summary: %0d items, %0d random scans, %0d register settings incl. extremes",
               items_sent, scans_sent, settings_used);
      $display("summary: comments, blanks, terminators and restarts; status side held off %0d cycles once",
               LONG_HOLD);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
